FILE: design/stt_pkg.sv
// shared types, constants and helpers for the sleep timeout table
// used by every module of the block but stt_ram; depends on nothing

package stt_pkg;

	localparam int SLOTS          = 16;
	localparam int WAITER_ID_BITS = 8;
	localparam int IDX_W          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W          = $clog2(SLOTS + 1);

	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [WAITER_ID_BITS-1:0] waiter_t;
	typedef logic [7:0]                id_t;

	typedef enum logic {
		KIND_ADD  = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		EV_ADD_OK   = 2'd0,
		EV_ADD_FULL = 2'd1,
		EV_WOKEN    = 2'd2,
		EV_NONE     = 2'd3
	} event_t;

	typedef struct packed {
		logic [63:0] start;
		logic [63:0] duration;
		waiter_t     waiter;
		logic        wakes;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		event_t ev;
		id_t    id;
		logic   last;
	} res_t;

	// table memory write and read request from the sequencer
	typedef struct packed {
		logic   we;
		idx_t   waddr;
		entry_t wdata;
		logic   re;
		idx_t   raddr;
	} ram_req_t;

	typedef struct packed {
		logic busy;
		cnt_t count;
	} stat_t;

	function automatic waiter_t to_waiter(id_t id);
		return waiter_t'(id);
	endfunction

	function automatic id_t to_id(waiter_t w);
		return id_t'(w);
	endfunction

endpackage

FILE: design/stt_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies

module stt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/stt_out_fifo.sv
// two-entry result queue in front of the master stream port
// depends on stt_pkg for the result type

module stt_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  stt_pkg::res_t din,
	output logic          full,
	output logic          out_valid,
	input  logic          out_ready,
	output stt_pkg::res_t dout
);

	stt_pkg::res_t slot_q [2];
	logic [1:0]    cnt_q;
	logic          pop;

	assign pop       = (cnt_q != 2'd0) && out_ready;
	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign dout      = slot_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				slot_q[cnt_q[0]] <= din;
			end
			2'b01: begin
				slot_q[0] <= slot_q[1];
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					slot_q[0] <= din;
				end else begin
					slot_q[0] <= slot_q[1];
					slot_q[1] <= din;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/stt_ctrl.sv
// sequencer: appends sleepers, scans and compacts the table on a tick
// depends on stt_pkg; drives the table ram and the result queue

module stt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  stt_pkg::kind_t   kind,
	input  logic [63:0]      now_ns,
	input  logic [63:0]      sleep_ns,
	input  stt_pkg::id_t     waiter_id,
	input  logic             has_wake,
	output stt_pkg::ram_req_t ram_req,
	input  stt_pkg::entry_t  rdata,
	input  logic             fifo_full,
	output logic             push,
	output stt_pkg::res_t    push_res,
	output stt_pkg::stat_t   stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t                state_q;
	stt_pkg::cnt_t         count_q;
	stt_pkg::cnt_t         keep_q;
	stt_pkg::idx_t         idx_q;
	logic [63:0]           now_q;
	logic                  pend_vld_q;
	stt_pkg::waiter_t      pend_id_q;

	logic                  accept;
	logic                  tbl_full;
	logic                  expired;
	logic                  wake;
	logic                  scan_go;
	logic                  scan_end;

	assign in_ready = (state_q == ST_IDLE) && !fifo_full;
	assign accept   = in_valid && in_ready;
	assign tbl_full = (count_q >= stt_pkg::cnt_t'(stt_pkg::SLOTS));
	assign expired  = ((now_q - rdata.start) >= rdata.duration);
	assign wake     = expired && rdata.wakes;
	// a held wake is released by the next one or in the final step
	assign scan_go  = !(wake && pend_vld_q && fifo_full);
	assign scan_end = ((stt_pkg::cnt_t'(idx_q) + stt_pkg::cnt_t'(1)) == count_q);

	assign stat.busy  = (state_q != ST_IDLE);
	assign stat.count = count_q;

	always_comb begin
		ram_req  = '0;
		push     = 1'b0;
		push_res = '{ev: stt_pkg::EV_NONE, id: '0, last: 1'b1};
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == stt_pkg::KIND_ADD) begin
						push        = 1'b1;
						push_res.id = stt_pkg::to_id(stt_pkg::to_waiter(waiter_id));
						if (tbl_full) begin
							push_res.ev = stt_pkg::EV_ADD_FULL;
						end else begin
							push_res.ev            = stt_pkg::EV_ADD_OK;
							ram_req.we             = 1'b1;
							ram_req.waddr          = count_q[stt_pkg::IDX_W-1:0];
							ram_req.wdata.start    = now_ns;
							ram_req.wdata.duration = sleep_ns;
							ram_req.wdata.waiter   = stt_pkg::to_waiter(waiter_id);
							ram_req.wdata.wakes    = has_wake;
						end
					end else if (count_q != '0) begin
						ram_req.re    = 1'b1;
						ram_req.raddr = '0;
					end
				end
			end
			ST_SCAN: begin
				if (scan_go) begin
					if (wake && pend_vld_q) begin
						push     = 1'b1;
						push_res = '{ev: stt_pkg::EV_WOKEN,
							id: stt_pkg::to_id(pend_id_q), last: 1'b0};
					end
					if (!expired) begin
						// survivor moves down to the compacted position
						ram_req.we    = 1'b1;
						ram_req.waddr = keep_q[stt_pkg::IDX_W-1:0];
						ram_req.wdata = rdata;
					end
					if (!scan_end) begin
						ram_req.re    = 1'b1;
						ram_req.raddr = idx_q + stt_pkg::idx_t'(1);
					end
				end
			end
			ST_FIN: begin
				if (!fifo_full) begin
					push = 1'b1;
					if (pend_vld_q) begin
						push_res = '{ev: stt_pkg::EV_WOKEN,
							id: stt_pkg::to_id(pend_id_q), last: 1'b1};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			keep_q     <= '0;
			idx_q      <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == stt_pkg::KIND_ADD) begin
							if (!tbl_full) begin
								count_q <= count_q + stt_pkg::cnt_t'(1);
							end
						end else begin
							now_q      <= now_ns;
							idx_q      <= '0;
							keep_q     <= '0;
							pend_vld_q <= 1'b0;
							state_q    <= (count_q != '0) ? ST_SCAN : ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						if (wake) begin
							pend_vld_q <= 1'b1;
							pend_id_q  <= rdata.waiter;
						end
						if (!expired) begin
							keep_q <= keep_q + stt_pkg::cnt_t'(1);
						end
						if (scan_end) begin
							state_q <= ST_FIN;
						end else begin
							idx_q <= idx_q + stt_pkg::idx_t'(1);
						end
					end
				end
				ST_FIN: begin
					if (!fifo_full) begin
						count_q <= keep_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/sleep_timeout_table_core.sv
// sleep timeout table: an add item's result is ready in the cycle after it is taken
// a tick item scans the stored sleepers with one ram read per sleeper, then ends in a final step,
// and stalls while the result queue stays full; one item in flight at a time
// reset clears the fill count and the result queue; the table ram is not
// cleared, only entries below the fill count are ever read
// depends on stt_pkg, stt_ram, stt_out_fifo and stt_ctrl

module sleep_timeout_table_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // now_ns, sleep_ns, waiter_id, has_wake, zero pad
	input  logic         s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata,  // event_res, woken_id, zero pad
	output logic         m_tlast
);

	stt_pkg::ram_req_t ram_req;
	logic [stt_pkg::ENTRY_W-1:0] ram_rdata;
	logic              fifo_full;
	logic              push;
	stt_pkg::res_t     push_res;
	stt_pkg::res_t     head;
	stt_pkg::stat_t    stat;

	stt_ram #(
		.WIDTH(stt_pkg::ENTRY_W),
		.DEPTH(stt_pkg::SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re   (ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	stt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.kind       (stt_pkg::kind_t'(s_tuser)),
		.now_ns     (s_tdata[63:0]),
		.sleep_ns   (s_tdata[127:64]),
		.waiter_id  (s_tdata[135:128]),
		.has_wake   (s_tdata[136]),
		.ram_req    (ram_req),
		.rdata      (stt_pkg::entry_t'(ram_rdata)),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_res   (push_res),
		.stat       (stat)
	);

	stt_out_fifo u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (push_res),
		.full     (fifo_full),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.dout     (head)
	);

	assign m_tdata = {6'b0, head.id, head.ev};
	assign m_tlast = head.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= stt_pkg::cnt_t'(stt_pkg::SLOTS))
		else $error("fill count beyond table size");

	a_full_add_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (stt_pkg::kind_t'(s_tuser) == stt_pkg::KIND_ADD)
			&& stat.count == stt_pkg::cnt_t'(stt_pkg::SLOTS))
		|=> stat.count == stt_pkg::cnt_t'(stt_pkg::SLOTS))
		else $error("rejected add changed the table");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full)
		else $error("result pushed into a full queue");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.busy)
		else $error("item taken while a tick scan runs");

endmodule
